/* hdl/simulated_order_fill_engine_defines.svh */
// Assertion macros shared by the order fill engine.
`ifndef SIMULATED_ORDER_FILL_ENGINE_DEFINES_SVH
`define SIMULATED_ORDER_FILL_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SOFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define SOFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/sofe_pkg.sv */
// ----------------------------------------------------------------------------
// sofe_pkg
// Report codes, request codes and field widths of the order fill engine.
// ----------------------------------------------------------------------------
package sofe_pkg;

    localparam int unsigned INST_W = 8;
    localparam int unsigned QTY_W  = 32;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned PTYPE_W = 3;
    localparam int unsigned WIRE_PRICE_W = 32;

    localparam logic OP_ORDER = 1'b0;
    localparam logic OP_QUOTE = 1'b1;

    localparam logic [PTYPE_W-1:0] PT_LIMIT = 3'd0;
    localparam logic [PTYPE_W-1:0] PT_ANY   = 3'd1;
    localparam logic [PTYPE_W-1:0] PT_FIVE  = 3'd3;
    localparam logic [PTYPE_W-1:0] PT_OTHER = 3'd4;

    localparam logic [KIND_W-1:0] KIND_SUBMITTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PENDING   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILLED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TRADE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;

    typedef struct packed {
        logic                    opcode;
        logic [INST_W-1:0]       instrument;
        logic                    side;
        logic [PTYPE_W-1:0]      px_kind;
        logic [WIRE_PRICE_W-1:0] price;
        logic [QTY_W-1:0]        quantity;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0]       report_kind;
        logic [NUM_W-1:0]        order_number;
        logic [INST_W-1:0]       report_instrument;
        logic                    report_side;
        logic [WIRE_PRICE_W-1:0] report_price;
        logic [QTY_W-1:0]        report_quantity;
        logic                    last_of_run;
    } t_rpt;

endpackage

/* hdl/sofe_if.sv */
// ----------------------------------------------------------------------------
// sofe_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sofe_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/simulated_order_fill_engine.sv */
// An order passes the read, decode and emit states before its first report, then gives one
// report per cycle while the output is not stalled. A quote is read and decoded, then walks the
// pending slots and reports each crossing order; one item is in the block at a time.
// The rate is set by the single price comparator walked over the pending slots.
// Reset (synchronous, active low) clears known flags, pending valid bits and the order counter;
// the price memory is not cleared.
// ----------------------------------------------------------------------------
// simulated_order_fill_engine
// Sequenced order and quote handler with a pending order table.
// ----------------------------------------------------------------------------
`include "simulated_order_fill_engine_defines.svh"

module simulated_order_fill_engine
    import sofe_pkg::*;
#(
    parameter int unsigned INSTRUMENT_SLOTS = 256,
    parameter int unsigned PENDING_SLOTS = 16,
    parameter int unsigned PRICE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sofe_if.sink      i_req,
    sofe_if.source    o_rpt
);

    localparam int unsigned IDX_W = (INSTRUMENT_SLOTS > 1) ? $clog2(INSTRUMENT_SLOTS) : 1;
    localparam int unsigned SLOT_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int unsigned PW = PRICE_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_DEC   = 7'b0000100,
        ST_EMIT  = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_SFILL = 7'b0100000,
        ST_STRD  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Request held for the whole item.
    t_req r_req;

    logic [INSTRUMENT_SLOTS-1:0] r_known;
    logic [PW-1:0] r_last_mem [INSTRUMENT_SLOTS];
    logic [PW-1:0] r_last_rd;

    logic [PENDING_SLOTS-1:0] r_pvalid;
    logic [INST_W-1:0]        r_pinst  [PENDING_SLOTS];
    logic                     r_pside  [PENDING_SLOTS];
    logic [PW-1:0]            r_pprice [PENDING_SLOTS];
    logic [QTY_W-1:0]         r_pqty   [PENDING_SLOTS];
    logic [NUM_W-1:0]         r_pnum   [PENDING_SLOTS];

    logic [NUM_W-1:0] r_counter;

    // Sequence of reports for an order, up to three.
    logic [KIND_W-1:0] r_k0, r_k1, r_k2;
    logic [1:0]        r_cnt, r_pos;
    logic              r_alloc;
    logic [SLOT_W-1:0] r_free;

    logic [SLOT_W:0] r_slot;
    logic [5:0]      r_nres;

    // A quote's trade report is held back until the scan has found the next fill or
    // reached the last slot, so that it knows whether it ends the run.
    logic [SLOT_W-1:0] r_tslot;
    logic              r_tpend;
    logic              r_tlast;

    t_rpt r_out;
    logic r_out_v;

    logic [IDX_W-1:0] w_idx;
    logic             w_in_range;
    logic [PW-1:0]    w_price;
    logic [SLOT_W-1:0] w_si;

    // Shared comparator: limit against last price for the given side.
    logic          w_cmp_side;
    logic [PW-1:0] w_cmp_lim, w_cmp_last;
    logic          w_cross;

    assign w_idx      = IDX_W'(r_req.instrument);
    assign w_in_range = ({24'd0, r_req.instrument} < 32'(INSTRUMENT_SLOTS));
    assign w_price    = PW'(r_req.price);
    assign w_si       = r_slot[SLOT_W-1:0];

    always_comb begin
        if (r_state == ST_DEC) begin
            w_cmp_side = r_req.side;
            w_cmp_lim  = w_price;
            w_cmp_last = r_last_rd;
        end else begin
            w_cmp_side = r_pside[w_si];
            w_cmp_lim  = r_pprice[w_si];
            w_cmp_last = w_price;
        end
        w_cross = w_cmp_side ? (w_cmp_lim <= w_cmp_last) : (w_cmp_lim >= w_cmp_last);
    end

    logic w_scan_hit, w_scan_end;
    assign w_scan_end = (r_slot == (SLOT_W+1)'(PENDING_SLOTS - 1));
    assign w_scan_hit = r_pvalid[w_si] && (r_pinst[w_si] == r_req.instrument) && w_cross
                        && (r_nres <= 6'd30);

    // The output register can take a new report when empty or being drained.
    logic w_out_free;
    logic w_load;
    assign w_out_free = !r_out_v || o_rpt.ready;
    assign w_load = w_out_free &&
                    ((r_state == ST_EMIT) || (r_state == ST_SFILL) || (r_state == ST_STRD));

    assign i_req.ready = (r_state == ST_IDLE) && !r_out_v;
    assign o_rpt.valid = r_out_v;
    assign o_rpt.payload = r_out;

    function automatic logic [WIRE_PRICE_W-1:0] wide_price(input logic [PW-1:0] p);
        wide_price = WIRE_PRICE_W'(p);
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_req.valid && i_req.ready) n_state = ST_READ;
            ST_READ:  n_state = ST_DEC;
            ST_DEC:   n_state = (r_req.opcode == OP_QUOTE) ?
                                (w_in_range ? ST_SCAN : ST_IDLE) : ST_EMIT;
            ST_EMIT:  if (w_out_free && (r_pos == r_cnt - 2'd1)) n_state = ST_IDLE;
            ST_SCAN: begin
                if (r_tpend && (w_scan_hit || w_scan_end)) n_state = ST_STRD;
                else if (w_scan_hit) n_state = ST_SFILL;
                else if (w_scan_end) n_state = ST_IDLE;
            end
            ST_SFILL: if (w_out_free) n_state = w_scan_end ? ST_STRD : ST_SCAN;
            ST_STRD:  if (w_out_free) n_state = r_tlast ? ST_IDLE : ST_SFILL;
            default:  n_state = ST_IDLE;
        endcase
    end

    logic [KIND_W-1:0] w_emit_kind;
    always_comb begin
        unique case (r_pos)
            2'd0:    w_emit_kind = r_k0;
            2'd1:    w_emit_kind = r_k1;
            default: w_emit_kind = r_k2;
        endcase
    end

    // Lowest free pending slot, one priority search over the valid bits.
    logic [SLOT_W-1:0] w_free;
    logic              w_has_free;
    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
            if (!r_pvalid[i]) begin
                w_free = SLOT_W'(i);
                w_has_free = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_req <= i_req.payload;
        if (r_state == ST_READ) r_last_rd <= r_last_mem[w_idx];
        if (r_state == ST_DEC && r_req.opcode == OP_QUOTE && w_in_range)
            r_last_mem[w_idx] <= w_price;
        if (r_state == ST_DEC && r_req.opcode == OP_ORDER) r_free <= w_free;
        if (r_state == ST_EMIT && r_alloc && w_out_free && r_pos == 2'd0) begin
            r_pinst[r_free]  <= r_req.instrument;
            r_pside[r_free]  <= r_req.side;
            r_pprice[r_free] <= w_price;
            r_pqty[r_free]   <= r_req.quantity;
            r_pnum[r_free]   <= r_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_known <= '0;
            r_pvalid <= '0;
            r_counter <= '0;
            r_out_v <= 1'b0;
            r_cnt <= '0;
            r_pos <= '0;
            r_alloc <= 1'b0;
            r_slot <= '0;
            r_nres <= '0;
            r_tpend <= 1'b0;
            r_tlast <= 1'b0;
            r_k0 <= KIND_SUBMITTED;
            r_k1 <= KIND_SUBMITTED;
            r_k2 <= KIND_SUBMITTED;
        end else begin
            r_state <= n_state;
            r_out_v <= w_load || (r_out_v && !o_rpt.ready);
            unique case (r_state)
                ST_IDLE: begin
                    r_slot <= '0;
                    r_nres <= '0;
                    r_pos <= '0;
                    r_alloc <= 1'b0;
                    r_tpend <= 1'b0;
                    r_tlast <= 1'b0;
                end
                ST_DEC: begin
                    if (r_req.opcode == OP_QUOTE) begin
                        if (w_in_range) r_known[w_idx] <= 1'b1;
                    end else if (!w_in_range || !r_known[w_idx]) begin
                        r_k0 <= KIND_ERROR;
                        r_cnt <= 2'd1;
                    end else begin
                        r_k0 <= KIND_SUBMITTED;
                        r_k1 <= KIND_FILLED;
                        r_k2 <= KIND_TRADE;
                        if (r_req.px_kind >= PT_ANY && r_req.px_kind <= PT_FIVE)
                            r_cnt <= 2'd3;
                        else if (r_req.px_kind == PT_LIMIT) begin
                            if (w_cross) r_cnt <= 2'd3;
                            else begin
                                r_cnt <= 2'd2;
                                r_k1 <= w_has_free ? KIND_PENDING : KIND_FULL;
                                r_alloc <= w_has_free;
                            end
                        end else r_cnt <= 2'd1;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out.report_kind <= w_emit_kind;
                        r_out.order_number <= r_counter;
                        r_out.report_instrument <= r_req.instrument;
                        r_out.report_side <= r_req.side;
                        r_out.report_price <= wide_price(w_price);
                        r_out.report_quantity <= r_req.quantity;
                        r_out.last_of_run <= (r_pos == r_cnt - 2'd1);
                        r_pos <= r_pos + 2'd1;
                        if (r_alloc && r_pos == 2'd0) r_pvalid[r_free] <= 1'b1;
                        if (r_pos == r_cnt - 2'd1 && r_k0 != KIND_ERROR)
                            r_counter <= r_counter + NUM_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (!w_scan_hit && !w_scan_end) r_slot <= r_slot + (SLOT_W+1)'(1);
                    r_tlast <= !w_scan_hit;
                end
                ST_SFILL: begin
                    if (w_out_free) begin
                        r_out.report_kind <= KIND_FILLED;
                        r_out.order_number <= r_pnum[w_si];
                        r_out.report_instrument <= r_pinst[w_si];
                        r_out.report_side <= r_pside[w_si];
                        r_out.report_price <= wide_price(r_pprice[w_si]);
                        r_out.report_quantity <= r_pqty[w_si];
                        r_out.last_of_run <= 1'b0;
                        // The count includes the trade report that follows.
                        r_nres <= r_nres + 6'd2;
                        r_pvalid[w_si] <= 1'b0;
                        r_tslot <= w_si;
                        r_tpend <= 1'b1;
                        if (w_scan_end) r_tlast <= 1'b1;
                        else r_slot <= r_slot + (SLOT_W+1)'(1);
                    end
                end
                ST_STRD: begin
                    if (w_out_free) begin
                        r_out.report_kind <= KIND_TRADE;
                        r_out.order_number <= r_pnum[r_tslot];
                        r_out.report_instrument <= r_pinst[r_tslot];
                        r_out.report_side <= r_pside[r_tslot];
                        r_out.report_price <= wide_price(r_pprice[r_tslot]);
                        r_out.report_quantity <= r_pqty[r_tslot];
                        r_out.last_of_run <= r_tlast;
                        r_tpend <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `SOFE_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n,
        r_state != ST_IDLE, !i_req.ready)
    `SOFE_ASSERT_NEXT(a_trade_then_fill, i_clk, i_rst_n,
        r_state == ST_STRD && w_out_free && !r_tlast, r_state == ST_SFILL)
    `SOFE_ASSERT_IMP(a_trade_held, i_clk, i_rst_n,
        r_state == ST_STRD, r_tpend)
    `SOFE_ASSERT_IMP(a_result_cap, i_clk, i_rst_n,
        r_state == ST_SFILL, r_nres <= 6'd30)

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Order fill engine testbench
// Sends orders and quotes over the request channel, predicts the reports from
// a behavioural copy of the order book, and compares every report field by
// field against the oldest expected report.
// ----------------------------------------------------------------------------
module testbench
    import sofe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_INST = 256;
    localparam int unsigned N_PEND = 16;
    localparam int unsigned RUN_CAP = 32;
    localparam int unsigned N_RANDOM = 133;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sofe_if #(.t_payload(t_req)) req_ch ();
    sofe_if #(.t_payload(t_rpt)) rpt_ch ();

    simulated_order_fill_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rpt   (rpt_ch)
    );

    always #2 i_clk = ~i_clk;

    // Behavioural copy of the book.
    logic              known [N_INST];
    logic [31:0]       last_px [N_INST];
    logic              book_vld [N_PEND];
    logic [INST_W-1:0] book_inst [N_PEND];
    logic              book_side [N_PEND];
    logic [31:0]       book_px [N_PEND];
    logic [QTY_W-1:0]  book_qty [N_PEND];
    logic [NUM_W-1:0]  book_num [N_PEND];
    logic [NUM_W-1:0]  next_num;

    t_rpt report_queue [$];
    int   n_err = 0;
    bit   sending_done = 0;

    function automatic bit crosses(logic side, logic [31:0] lim, logic [31:0] last);
        return side == 1'b0 ? (lim >= last) : (lim <= last);
    endfunction

    function automatic t_rpt mk_rpt(logic [KIND_W-1:0] k, logic [NUM_W-1:0] num,
                                    logic [INST_W-1:0] inst, logic side,
                                    logic [31:0] px, logic [QTY_W-1:0] qty);
        t_rpt r;
        r.report_kind = k;
        r.order_number = num;
        r.report_instrument = inst;
        r.report_side = side;
        r.report_price = px;
        r.report_quantity = qty;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Works out the reports of one request and updates the book.
    function automatic void predict_reports(t_req q);
        t_rpt run [$];
        int   slot;
        slot = -1;
        if (q.opcode == OP_QUOTE) begin
            known[q.instrument] = 1'b1;
            last_px[q.instrument] = q.price;
            for (int i = 0; i < N_PEND; i++) begin
                if (run.size() + 2 > RUN_CAP) break;
                if (book_vld[i] && book_inst[i] == q.instrument &&
                    crosses(book_side[i], book_px[i], q.price)) begin
                    run.push_back(mk_rpt(KIND_FILLED, book_num[i], q.instrument,
                                         book_side[i], book_px[i], book_qty[i]));
                    run.push_back(mk_rpt(KIND_TRADE, book_num[i], q.instrument,
                                         book_side[i], book_px[i], book_qty[i]));
                    book_vld[i] = 1'b0;
                end
            end
        end else if (!known[q.instrument]) begin
            run.push_back(mk_rpt(KIND_ERROR, next_num, q.instrument, q.side,
                                 q.price, q.quantity));
        end else begin
            run.push_back(mk_rpt(KIND_SUBMITTED, next_num, q.instrument, q.side,
                                 q.price, q.quantity));
            if (q.px_kind >= PT_ANY && q.px_kind <= PT_FIVE ||
                q.px_kind == PT_LIMIT &&
                crosses(q.side, q.price, last_px[q.instrument])) begin
                run.push_back(mk_rpt(KIND_FILLED, next_num, q.instrument, q.side,
                                     q.price, q.quantity));
                run.push_back(mk_rpt(KIND_TRADE, next_num, q.instrument, q.side,
                                     q.price, q.quantity));
            end else if (q.px_kind == PT_LIMIT) begin
                for (int i = 0; i < N_PEND; i++)
                    if (!book_vld[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    run.push_back(mk_rpt(KIND_FULL, next_num, q.instrument, q.side,
                                         q.price, q.quantity));
                end else begin
                    book_vld[slot] = 1'b1;
                    book_inst[slot] = q.instrument;
                    book_side[slot] = q.side;
                    book_px[slot] = q.price;
                    book_qty[slot] = q.quantity;
                    book_num[slot] = next_num;
                    run.push_back(mk_rpt(KIND_PENDING, next_num, q.instrument, q.side,
                                         q.price, q.quantity));
                end
            end
            next_num = next_num + 1;
        end
        if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i]) report_queue.push_back(run[i]);
    endfunction

    // Directed rows; a known report is typed in where it is obvious.
    typedef struct {
        t_req q;
        bit   has_exp;
        t_rpt exp_rpt;
    } t_row;

    t_row rows [$];

    function automatic t_req mk_req(logic op, logic [7:0] inst, logic side,
                                    logic [2:0] pt, logic [31:0] px, logic [31:0] qty);
        t_req q;
        q.opcode = op;
        q.instrument = inst;
        q.side = side;
        q.px_kind = pt;
        q.price = px;
        q.quantity = qty;
        return q;
    endfunction

    function automatic void add_row(t_req q);
        t_row r;
        r.q = q;
        r.has_exp = 0;
        r.exp_rpt = '0;
        rows.push_back(r);
    endfunction

    function automatic void build_rows();
        t_row r;
        // Order before any quote: unknown instrument error with number zero.
        r.q = mk_req(OP_ORDER, 8'd255, 1'b1, PT_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        r.has_exp = 1;
        r.exp_rpt = mk_rpt(KIND_ERROR, '0, 8'd255, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        r.exp_rpt.last_of_run = 1'b1;
        rows.push_back(r);
        add_row(mk_req(OP_QUOTE, 8'd0, 1'b0, PT_LIMIT, 32'd1000, 32'd0));   // no fills
        add_row(mk_req(OP_QUOTE, 8'd255, 1'b1, PT_LIMIT, 32'hFFFF_FFFF, 32'd5));
        for (int pt = 0; pt < 8; pt++)
            add_row(mk_req(OP_ORDER, 8'd0, pt[0], pt[2:0], 32'd1000, 32'd10 + pt));
        add_row(mk_req(OP_ORDER, 8'd0, 1'b0, PT_LIMIT, 32'd999, 32'd1));     // rests
        add_row(mk_req(OP_ORDER, 8'd0, 1'b1, PT_LIMIT, 32'd1001, 32'd2));    // rests
        add_row(mk_req(OP_ORDER, 8'd255, 1'b0, PT_LIMIT, 32'd0, 32'd0));     // rests
        add_row(mk_req(OP_ORDER, 8'd255, 1'b1, PT_LIMIT, 32'hFFFF_FFFF, 32'd3)); // crosses
        add_row(mk_req(OP_QUOTE, 8'd0, 1'b0, PT_LIMIT, 32'd999, 32'd0));  // fills buy
        add_row(mk_req(OP_QUOTE, 8'd0, 1'b0, PT_LIMIT, 32'd1001, 32'd0)); // fills sell
        add_row(mk_req(OP_QUOTE, 8'd255, 1'b0, PT_LIMIT, 32'd0, 32'd0));
        // Quote instrument 7 at price zero so that the resting sells sent later fill the book and overflow it.
        add_row(mk_req(OP_QUOTE, 8'd7, 1'b0, PT_LIMIT, 32'd0, 32'd0));
    endfunction

    int mismatches_shown = 0;

    task automatic note_mismatch(t_rpt e, t_rpt a);
        n_err++;
        if (mismatches_shown < 10) begin
            mismatches_shown++;
            $display("report mismatch: expected %p, got %p", e, a);
        end
    endtask

    // Report side: random stall pattern and in-order comparison.
    t_rpt fixed_exp [$];

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rpt_ch.ready <= 1'b0;
        end else begin
            if (rpt_ch.valid && rpt_ch.ready) begin
                if (report_queue.size() == 0) begin
                    n_err++;
                    if (mismatches_shown < 10) begin
                        mismatches_shown++;
                        $display("unexpected report %p", rpt_ch.payload);
                    end
                end else begin
                    t_rpt e;
                    e = report_queue.pop_front();
                    if (e !== rpt_ch.payload) note_mismatch(e, rpt_ch.payload);
                    if (fixed_exp.size() > 0) begin
                        if (fixed_exp[0] !== rpt_ch.payload)
                            note_mismatch(fixed_exp[0], rpt_ch.payload);
                        void'(fixed_exp.pop_front());
                    end
                end
            end
            // Long stretches of full readiness alternate with choppy stalls.
            rpt_ch.ready <= (($time / 2000) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send(t_req q);
        req_ch.payload <= q;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_reports(q);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (report_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req random_req();
        t_req q;
        int   sel;
        sel = $urandom_range(0, 99);
        q = mk_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 5)),
                   1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   32'd900 + 32'($urandom_range(0, 200)), $urandom());
        // Mostly a few hot instruments and prices near each other, so orders
        // rest and later quotes sweep them; the rest is full-range noise.
        if (q.opcode == OP_ORDER && sel < 50) q.px_kind = PT_LIMIT;
        if (sel >= 90) begin
            q.instrument = 8'($urandom());
            q.price = $urandom();
        end
        return q;
    endfunction

    initial begin
        int burst;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        for (int i = 0; i < N_INST; i++) known[i] = 1'b0;
        for (int i = 0; i < N_PEND; i++) book_vld[i] = 1'b0;
        next_num = '0;
        build_rows();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].has_exp) fixed_exp.push_back(rows[i].exp_rpt);
            send(rows[i].q);
            if ($urandom_range(0, 2) == 0) idle_gap();
        end
        // Seventeen resting sells on instrument 7: the last finds the book full.
        for (int i = 0; i < 17; i++)
            send(mk_req(OP_ORDER, 8'd7, 1'b1, PT_LIMIT, 32'd100 + i, i));
        // Hold off until the book has settled, then sweep it in one quote.
        drain();
        send(mk_req(OP_QUOTE, 8'd7, 1'b0, PT_LIMIT, 32'hFFFF_FFFF, 32'd0));

        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (burst == 0) begin
                idle_gap();
                burst = $urandom_range(1, 12);
            end
            send(random_req());
            burst--;
        end
        req_ch.valid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_err == 0 && report_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end
endmodule
